[rtl/i2cm_pkg.sv]
package i2cm_pkg;

   localparam int DELAY_BITS  = 10;
   localparam int CSR_W       = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_DELAY = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_DELAY  = 1'd1;

   localparam logic [CSR_W-1:0] SHORT_DELAY_RESET = 10'd64;
   localparam logic [CSR_W-1:0] LONG_DELAY_RESET  = 10'd80;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;
   localparam logic [3:0] ACK_BITS      = 4'd1;

   localparam logic [7:0] BYTE_RELEASED = 8'hFF;
   localparam logic [7:0] BYTE_ACK      = 8'h00;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_STOP  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_START   = 2'd1,
      ST_ADDR_NACK  = 2'd2,
      ST_DATA_NACK  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_START,
      KIND_WRITE,
      KIND_READ,
      KIND_STOP
   } cmd_kind_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] action;
      logic [6:0] target_address;
      logic       read_flag;
      logic [7:0] write_byte;
      logic       read_nack;
      logic       sda_in;
      logic       scl_in;
   } req_type;

   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [6:0]   target_address;
      logic         read_flag;
      logic [7:0]   write_byte;
      logic         read_nack;
      logic         sda_in;
      logic         scl_in;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

endpackage

[rtl/i2cm_front.sv]
module i2cm_front (
   input  logic                  req_valid,
   input  i2cm_pkg::req_type     req_data,
   output logic                  req_stall,
   input  i2cm_pkg::q_status_type q_status,
   output logic                  push,
   output i2cm_pkg::entry_type   push_entry
);

   i2cm_pkg::cmd_kind_type kind;

   always_comb begin
      kind = i2cm_pkg::KIND_NONE;
      if (req_data.cmd_valid) begin
         unique case (i2cm_pkg::action_type'(req_data.action))
            i2cm_pkg::ACT_START: kind = i2cm_pkg::KIND_START;
            i2cm_pkg::ACT_WRITE: kind = i2cm_pkg::KIND_WRITE;
            i2cm_pkg::ACT_READ:  kind = i2cm_pkg::KIND_READ;
            i2cm_pkg::ACT_STOP:  kind = i2cm_pkg::KIND_STOP;
            default:             kind = i2cm_pkg::KIND_NONE;
         endcase
      end
   end

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   assign push_entry.kind           = kind;
   assign push_entry.target_address = req_data.target_address;
   assign push_entry.read_flag      = req_data.read_flag;
   assign push_entry.write_byte     = req_data.write_byte;
   assign push_entry.read_nack      = req_data.read_nack;
   assign push_entry.sda_in         = req_data.sda_in;
   assign push_entry.scl_in         = req_data.scl_in;

endmodule

[rtl/i2cm_queue.sv]
module i2cm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  i2cm_pkg::entry_type    push_entry,
   input  logic                   pop,
   output i2cm_pkg::entry_type    pop_entry,
   output i2cm_pkg::q_status_type q_status
);

   localparam int PTR_W = (i2cm_pkg::QUEUE_DEPTH > 1) ? $clog2(i2cm_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(i2cm_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(i2cm_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(i2cm_pkg::QUEUE_DEPTH);

   i2cm_pkg::entry_type mem_ff [i2cm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign q_status.not_empty = (count_ff != '0);
   assign q_status.full      = (count_ff == FULL_CNT);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && q_status.not_empty;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/i2cm_back.sv]
module i2cm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [i2cm_pkg::CSR_W-1:0]          csr_wdata,
   input  i2cm_pkg::q_status_type              q_status,
   input  i2cm_pkg::entry_type                 entry,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output i2cm_pkg::rsp_type                   rsp_data
);

   localparam int DB = i2cm_pkg::DELAY_BITS;
   localparam logic [DB-1:0] DC_ONE = DB'(1);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SWAIT,
      PH_SSETUP,
      PH_SHOLD,
      PH_BLOW,
      PH_BWAIT,
      PH_BHIGH,
      PH_TAIL,
      PH_PWAIT,
      PH_PHOLD,
      PH_PTAIL
   } phase_type;

   function automatic logic [DB-1:0] load_delay(input logic [i2cm_pkg::CSR_W-1:0] ticks);
      logic [31:0] t;
      logic [31:0] maxv;
      t    = 32'(ticks);
      maxv = (32'd1 << DB) - 32'd1;
      if (t == 32'd0) t = 32'd1;
      if (t > maxv) t = maxv;
      return DB'(t);
   endfunction

   logic [i2cm_pkg::CSR_W-1:0] short_ff, long_ff;

   phase_type            phase_ff, phase_in;
   logic [3:0]           bits_ff, bits_in;
   logic [7:0]           shift_ff, shift_in;
   logic [DB-1:0]        dc_ff, dc_in;
   logic [7:0]           rx_ff, rx_in;
   logic                 scl_low_ff, scl_low_in;
   logic                 sda_low_ff, sda_low_in;
   i2cm_pkg::action_type act_ff, act_in;
   logic                 stage_ff, stage_in;
   logic                 nack_ff, nack_in;
   i2cm_pkg::status_type status_ff, status_in;
   logic                 rsp_valid_ff;
   i2cm_pkg::rsp_type    rsp_ff, rsp_in;

   logic       out_ready, step;
   logic       dly_over;
   logic [DB-1:0] dly_dec;
   logic [3:0] bl;
   logic [7:0] got;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign step      = q_status.not_empty && out_ready;
   assign pop       = step;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign dly_over = (dc_ff <= DC_ONE);
   assign dly_dec  = dc_ff - DC_ONE;

   always_comb begin
      phase_in   = phase_ff;
      bits_in    = bits_ff;
      shift_in   = shift_ff;
      dc_in      = dc_ff;
      rx_in      = rx_ff;
      scl_low_in = scl_low_ff;
      sda_low_in = sda_low_ff;
      act_in     = act_ff;
      stage_in   = stage_ff;
      nack_in    = nack_ff;
      status_in  = status_ff;
      rsp_in     = '0;
      bl         = bits_ff;
      got        = shift_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            stage_in = 1'b0;
            unique case (entry.kind)
               i2cm_pkg::KIND_START: begin
                  act_in     = i2cm_pkg::ACT_START;
                  shift_in   = {entry.target_address, entry.read_flag};
                  scl_low_in = 1'b0;
                  sda_low_in = 1'b0;
                  phase_in   = PH_SWAIT;
               end
               i2cm_pkg::KIND_WRITE: begin
                  act_in     = i2cm_pkg::ACT_WRITE;
                  shift_in   = entry.write_byte;
                  bits_in    = i2cm_pkg::BITS_PER_BYTE;
                  sda_low_in = ~entry.write_byte[7];
                  scl_low_in = 1'b1;
                  dc_in      = load_delay(long_ff);
                  phase_in   = PH_BLOW;
               end
               i2cm_pkg::KIND_READ: begin
                  act_in     = i2cm_pkg::ACT_READ;
                  nack_in    = entry.read_nack;
                  shift_in   = i2cm_pkg::BYTE_RELEASED;
                  bits_in    = i2cm_pkg::BITS_PER_BYTE;
                  sda_low_in = 1'b0;
                  scl_low_in = 1'b1;
                  dc_in      = load_delay(long_ff);
                  phase_in   = PH_BLOW;
               end
               i2cm_pkg::KIND_STOP: begin
                  act_in     = i2cm_pkg::ACT_STOP;
                  sda_low_in = 1'b1;
                  scl_low_in = 1'b0;
                  phase_in   = PH_PWAIT;
               end
               default: begin
                  stage_in = stage_ff;
               end
            endcase
         end
         PH_SWAIT: begin
            if (entry.scl_in) begin
               dc_in    = load_delay(long_ff);
               phase_in = PH_SSETUP;
            end
         end
         PH_SSETUP: begin
            if (dly_over) begin
               sda_low_in = 1'b1;
               dc_in      = load_delay(short_ff);
               phase_in   = PH_SHOLD;
            end else begin
               dc_in = dly_dec;
            end
         end
         PH_SHOLD: begin
            if (dly_over) begin
               scl_low_in = 1'b1;
               sda_low_in = 1'b0;
               if (!entry.sda_in && entry.scl_in) begin
                  bits_in    = i2cm_pkg::BITS_PER_BYTE;
                  sda_low_in = ~shift_ff[7];
                  dc_in      = load_delay(long_ff);
                  phase_in   = PH_BLOW;
               end else begin
                  phase_in  = PH_IDLE;
                  rsp_in.done_res = 1'b1;
                  status_in = i2cm_pkg::ST_NO_START;
               end
            end else begin
               dc_in = dly_dec;
            end
         end
         PH_BLOW: begin
            if (dly_over) begin
               scl_low_in = 1'b0;
               phase_in   = PH_BWAIT;
            end else begin
               dc_in = dly_dec;
            end
         end
         PH_BWAIT: begin
            if (entry.scl_in) begin
               shift_in = {shift_ff[6:0], entry.sda_in};
               dc_in    = load_delay(short_ff);
               phase_in = PH_BHIGH;
            end
         end
         PH_BHIGH: begin
            if (dly_over) begin
               scl_low_in = 1'b1;
               if (bl != 4'd0) bl = bl - 4'd1;
               bits_in = bl;
               dc_in   = load_delay(long_ff);
               if (bl != 4'd0) begin
                  sda_low_in = ~shift_ff[7];
                  phase_in   = PH_BLOW;
               end else begin
                  phase_in = PH_TAIL;
               end
            end else begin
               dc_in = dly_dec;
            end
         end
         PH_TAIL: begin
            if (dly_over) begin
               got        = shift_ff;
               shift_in   = i2cm_pkg::BYTE_RELEASED;
               sda_low_in = 1'b0;
               priority if (!stage_ff) begin
                  if (act_ff == i2cm_pkg::ACT_READ) begin
                     rx_in    = got;
                     shift_in = nack_ff ? i2cm_pkg::BYTE_RELEASED : i2cm_pkg::BYTE_ACK;
                  end
                  stage_in   = 1'b1;
                  bits_in    = i2cm_pkg::ACK_BITS;
                  sda_low_in = ~shift_in[7];
                  scl_low_in = 1'b1;
                  dc_in      = load_delay(long_ff);
                  phase_in   = PH_BLOW;
               end else if (act_ff == i2cm_pkg::ACT_READ || !got[0]) begin
                  phase_in        = PH_IDLE;
                  rsp_in.done_res = 1'b1;
                  status_in       = i2cm_pkg::ST_OK;
               end else begin
                  phase_in        = PH_IDLE;
                  rsp_in.done_res = 1'b1;
                  status_in       = (act_ff == i2cm_pkg::ACT_START) ?
                                    i2cm_pkg::ST_ADDR_NACK : i2cm_pkg::ST_DATA_NACK;
               end
            end else begin
               dc_in = dly_dec;
            end
         end
         PH_PWAIT: begin
            if (entry.scl_in) begin
               dc_in    = load_delay(short_ff);
               phase_in = PH_PHOLD;
            end
         end
         PH_PHOLD: begin
            if (dly_over) begin
               sda_low_in = 1'b0;
               dc_in      = load_delay(long_ff);
               phase_in   = PH_PTAIL;
            end else begin
               dc_in = dly_dec;
            end
         end
         PH_PTAIL: begin
            if (dly_over) begin
               phase_in        = PH_IDLE;
               rsp_in.done_res = 1'b1;
               status_in       = i2cm_pkg::ST_OK;
            end else begin
               dc_in = dly_dec;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      rsp_in.scl_pull_low = scl_low_in;
      rsp_in.sda_pull_low = sda_low_in;
      rsp_in.busy_res     = (phase_in != PH_IDLE);
      rsp_in.status       = status_in;
      rsp_in.read_data    = rx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff     <= i2cm_pkg::SHORT_DELAY_RESET;
         long_ff      <= i2cm_pkg::LONG_DELAY_RESET;
         phase_ff     <= PH_IDLE;
         bits_ff      <= '0;
         shift_ff     <= i2cm_pkg::BYTE_RELEASED;
         dc_ff        <= '0;
         rx_ff        <= '0;
         scl_low_ff   <= 1'b0;
         sda_low_ff   <= 1'b0;
         act_ff       <= i2cm_pkg::ACT_START;
         stage_ff     <= 1'b0;
         nack_ff      <= 1'b0;
         status_ff    <= i2cm_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               i2cm_pkg::CSR_SHORT_DELAY: short_ff <= csr_wdata;
               i2cm_pkg::CSR_LONG_DELAY:  long_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (step) begin
            phase_ff     <= phase_in;
            bits_ff      <= bits_in;
            shift_ff     <= shift_in;
            dc_ff        <= dc_in;
            rx_ff        <= rx_in;
            scl_low_ff   <= scl_low_in;
            sda_low_ff   <= sda_low_in;
            act_ff       <= act_in;
            stage_ff     <= stage_in;
            nack_ff      <= nack_in;
            status_ff    <= status_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[rtl/i2c_master_byte_engine_top.sv]
// I2C master byte engine. Every item is one clock tick of the bus: an optional command plus the
// sampled SDA and SCL levels, and every item yields exactly one result carrying the open-drain
// pull-lows, busy, done, status and the last byte read. One item is accepted per cycle while the
// queue is not full. An accepted item is classified into a two-entry queue and the engine
// advances its bus state machine by one step per queued item; the item passes through the queue
// and its result is registered in the result register. Throughput is one item per cycle, set by
// the single-step state update of the engine; a stalled result register holds the engine and,
// once the queue fills, stalls the request side. Delay registers are written through the csr
// port; the user must write them only while the bus is idle, the block does not enforce this.
module i2c_master_byte_engine_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  i2cm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output i2cm_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [i2cm_pkg::CSR_W-1:0]       csr_wdata
);

   i2cm_pkg::q_status_type q_status;
   i2cm_pkg::entry_type    push_entry;
   i2cm_pkg::entry_type    pop_entry;
   logic                   push;
   logic                   pop;

   i2cm_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   i2cm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   i2cm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .entry     (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/i2cm_checker.sv]
module i2cm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input i2cm_pkg::rsp_type rsp_data
);

   // no stale result or back-pressure right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled right after reset");

   // a finished command leaves the engine idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done reported while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
